[design/lkv_pkg.sv]
`timescale 1ns / 1ps

package lkv_pkg;

  // Fixed field widths
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_ENTRIES = 16;
  localparam int DEF_CAPACITY    = 16;

  // Returned by a get that finds nothing
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // Request codes
  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_UPD
  } lkv_state_t;

  // Signals passed from one cell to the next along the row
  typedef struct packed {
    logic                     found;
    logic                     free_seen;
    logic signed [DATA_W-1:0] value;
  } lkv_chain_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                     look;
    logic                     upd;
    logic                     clear;
    logic                     put;
    logic                     hit_any;
    logic                     full;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkv_ctl_t;

endpackage

[design/lkv_req_if.sv]
`timescale 1ns / 1ps

interface lkv_req_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

[design/lkv_rsp_if.sv]
`timescale 1ns / 1ps

interface lkv_rsp_if import lkv_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     hit;
  logic signed [DATA_W-1:0] read_value;
  logic                     evicted;

  modport source (output valid, output hit, output read_value, output evicted, input ready);
  modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

[design/lkv_cfg_if.sv]
`timescale 1ns / 1ps

interface lkv_cfg_if import lkv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

[design/lru_key_value_cache.sv]
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement,
// built as a row of MAX_ENTRIES cells, each holding one key, value and
// recency rank. Every request goes through the transfer in, a lookup in which
// all cells compare the key at once and pass the match, read data and
// free-slot priority along the row, and an update in which the cells
// re-rank and the result is loaded into the output register; that update waits
// while the register holds an untransferred result, but a new request is
// taken while the previous result still waits to be transferred. A get returns
// the stored value with hit high, or -1 with hit low. A put replaces or inserts,
// evicting the least recent entry when the store already holds capacity
// entries. Writing capacity (0 taken as 1, above MAX_ENTRIES saturated) empties
// the store at once; it is to be written only while no request is in flight.
module lru_key_value_cache import lkv_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
  input logic       clk,
  input logic       rst_n,
  lkv_req_if.sink   in_req,
  lkv_rsp_if.source out_rsp,
  lkv_cfg_if.sink   cfg_wr
);

  localparam int AGE_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int RST_CAP = (DEF_CAPACITY > MAX_ENTRIES) ? MAX_ENTRIES : DEF_CAPACITY;

  lkv_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         cap_r, cap_nxt;
  logic                     put_r;
  logic signed [DATA_W-1:0] key_r;
  logic signed [DATA_W-1:0] val_r;
  logic                     hit_any_r;
  logic signed [DATA_W-1:0] rd_r;
  logic [AGE_W-1:0]         hit_age_r;
  logic                     out_valid_r;
  logic                     out_hit_r;
  logic signed [DATA_W-1:0] out_value_r;
  logic                     out_evicted_r;

  logic             in_rdy;
  logic             in_fire;
  logic             look;
  logic             upd;
  logic             cfg_fire;
  logic             full;
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] cap_sat;
  logic [AGE_W-1:0] cnt_m1;
  lkv_ctl_t         ctl;

  lkv_chain_t       chain    [MAX_ENTRIES+1];
  logic [AGE_W-1:0] age_chain[MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] valid_vec;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] sel_vec;

  // Handshakes
  assign in_fire  = in_req.valid && in_rdy;
  assign cfg_fire = cfg_wr.valid;
  assign in_req.ready = in_rdy;
  assign cfg_wr.ready = 1'b1;

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.hit        = out_hit_r;
  assign out_rsp.read_value = out_value_r;
  assign out_rsp.evicted    = out_evicted_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_LOOK;
      ST_LOOK: state_nxt = ST_UPD;
      ST_UPD:  if (!out_valid_r || out_rsp.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_rdy = 1'b0;
    look   = 1'b0;
    upd    = 1'b0;
    case (state_r)
      ST_IDLE: in_rdy = 1'b1;
      ST_LOOK: look = 1'b1;
      ST_UPD:  upd = !out_valid_r || out_rsp.ready;
      default: in_rdy = 1'b0;
    endcase
  end

  // Saturate the written capacity into 1..MAX_ENTRIES
  always_comb begin
    cap_ext = CMP_W'(cfg_wr.capacity);
    if (cap_ext == '0) begin
      cap_sat = CMP_W'(1);
    end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
      cap_sat = CMP_W'(MAX_ENTRIES);
    end else begin
      cap_sat = cap_ext;
    end
    cap_nxt = cfg_fire ? CNT_W'(cap_sat) : cap_r;
  end

  assign full   = count_r >= cap_r;
  assign cnt_m1 = AGE_W'(count_r - 1'b1);

  // Advance the fill count
  always_comb begin
    count_nxt = count_r;
    if (cfg_fire) begin
      count_nxt = '0;
    end else if (upd && (put_r == REQ_PUT) && !hit_any_r && !full) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end
  end

  // Broadcast to the row
  always_comb begin
    ctl.look    = look;
    ctl.upd     = upd;
    ctl.clear   = cfg_fire;
    ctl.put     = put_r;
    ctl.hit_any = hit_any_r;
    ctl.full    = full;
    ctl.key     = key_r;
    ctl.value   = val_r;
  end

  assign chain[0]     = '{found: 1'b0, free_seen: 1'b0, value: '0};
  assign age_chain[0] = '0;

  // Row of cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .AGE_W (AGE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .hit_age   (hit_age_r),
      .cnt_m1    (cnt_m1),
      .chain_in  (chain[i]),
      .age_in    (age_chain[i]),
      .chain_out (chain[i+1]),
      .age_out   (age_chain[i+1]),
      .valid     (valid_vec[i]),
      .hit       (hit_vec[i]),
      .sel       (sel_vec[i])
    );
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cap_r       <= CNT_W'(RST_CAP);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      cap_r   <= cap_nxt;
      if (upd) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request, lookup and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      put_r <= in_req.req_type;
      key_r <= in_req.key;
      val_r <= in_req.value;
    end
    if (look) begin
      hit_any_r <= chain[MAX_ENTRIES].found;
      rd_r      <= chain[MAX_ENTRIES].value;
      hit_age_r <= age_chain[MAX_ENTRIES];
    end
    if (upd) begin
      out_hit_r     <= hit_any_r;
      out_evicted_r <= (put_r == REQ_PUT) && !hit_any_r && full;
      if (put_r == REQ_PUT) begin
        out_value_r <= '0;
      end else if (hit_any_r) begin
        out_value_r <= rd_r;
      end else begin
        out_value_r <= MISS_VALUE;
      end
    end
  end

`ifndef SYNTH
  // Keys are unique, so at most one cell can match
  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(hit_vec))
    else $error("more than one cell matched the key");

  // An insert picks exactly one slot
  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_UPD) && (put_r == REQ_PUT) && !hit_any_r) |-> $onehot(sel_vec))
    else $error("insert did not select exactly one slot");

  // Fill count tracks the valid entries
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_vec) == 32'(count_r)))
    else $error("fill count disagrees with valid entries");

  // Store never holds more than capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= cap_r))
    else $error("fill count above capacity");

  // A transfer in starts a lookup
  a_in_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_LOOK))
    else $error("accepted request did not start a lookup");
`endif

endmodule

[design/lkv_cell.sv]
`timescale 1ns / 1ps

module lkv_cell import lkv_pkg::*; #(
  parameter int AGE_W = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lkv_ctl_t         ctl,
  input  logic [AGE_W-1:0] hit_age,
  input  logic [AGE_W-1:0] cnt_m1,
  input  lkv_chain_t       chain_in,
  input  logic [AGE_W-1:0] age_in,
  output lkv_chain_t       chain_out,
  output logic [AGE_W-1:0] age_out,
  output logic             valid,
  output logic             hit,
  output logic             sel
);

  logic                     valid_r, valid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic signed [DATA_W-1:0] value_r, value_nxt;
  logic [AGE_W-1:0]         age_r, age_nxt;
  logic                     hit_r, hit_nxt;
  logic                     sel_r, sel_nxt;
  logic                     match;
  logic                     victim;
  logic                     first_free;

  // Compare the request key against this entry
  assign match      = valid_r && (key_r == ctl.key);
  assign victim     = valid_r && (age_r == cnt_m1);
  assign first_free = !valid_r && !chain_in.free_seen;

  // Pass match, read data and free-slot priority on to the neighbour
  assign chain_out.found     = chain_in.found | match;
  assign chain_out.free_seen = chain_in.free_seen | !valid_r;
  assign chain_out.value     = chain_in.value | (match ? value_r : '0);
  assign age_out             = age_in | (match ? age_r : '0);

  assign valid = valid_r;
  assign hit   = hit_r;
  assign sel   = sel_r;

  // Work out the next entry contents
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    age_nxt   = age_r;
    hit_nxt   = hit_r;
    sel_nxt   = sel_r;
    if (ctl.look) begin
      hit_nxt = match;
      sel_nxt = ctl.full ? victim : first_free;
    end
    if (ctl.upd) begin
      if (ctl.hit_any) begin
        // Promote the hit entry, age those that were younger
        if (hit_r) begin
          age_nxt = '0;
          if (ctl.put) begin
            value_nxt = ctl.value;
          end
        end else if (valid_r && (age_r < hit_age)) begin
          age_nxt = AGE_W'(age_r + 1'b1);
        end
      end else if (ctl.put) begin
        // Insert into the chosen slot, age all the others
        if (sel_r) begin
          valid_nxt = 1'b1;
          key_nxt   = ctl.key;
          value_nxt = ctl.value;
          age_nxt   = '0;
        end else if (valid_r) begin
          age_nxt = AGE_W'(age_r + 1'b1);
        end
      end
    end
    if (ctl.clear) begin
      valid_nxt = 1'b0;
    end
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r   <= key_nxt;
    value_r <= value_nxt;
    age_r   <= age_nxt;
    hit_r   <= hit_nxt;
    sel_r   <= sel_nxt;
  end

endmodule
